FILE: hdl/psbc_pkg.sv
// shared constants, codes and control types of the swing-up and balance controller
package psbc_pkg;

  localparam longint COUNTS_PER_REV = 4096;
  localparam longint TICK_NS = 2000000;
  localparam longint CENTER_OFFSET = 6145;
  localparam int REV_BITS = $clog2(COUNTS_PER_REV);
  localparam longint HALF_REV = COUNTS_PER_REV / 2;

  localparam longint CART_NM_PER_REV = 149964849;
  localparam longint TWO_PI_E6 = 6283185;
  localparam longint GAIN_SCALE = 4194304;
  localparam longint VEL_CLAMP = 1048576;
  localparam longint RT = COUNTS_PER_REV * TICK_NS;

  // gains, drive lsb per count (8 fraction bits), rounded half away from zero
  localparam longint D_CART = 64'sd1000000000000 * COUNTS_PER_REV;
  localparam longint KP_SWING =
    -((3800 * CART_NM_PER_REV * GAIN_SCALE + D_CART / 2) / D_CART);
  localparam longint KP_BAL = (3800 * CART_NM_PER_REV * GAIN_SCALE + D_CART / 2) / D_CART;
  localparam longint KD_BAL =
    (2400 * CART_NM_PER_REV * GAIN_SCALE + 500 * RT) / (1000 * RT);
  localparam longint D_PEND = 1000000000 * COUNTS_PER_REV;
  localparam longint KPP_BAL = (5700 * TWO_PI_E6 * GAIN_SCALE + D_PEND / 2) / D_PEND;
  localparam longint KDP_BAL = (800 * TWO_PI_E6 * GAIN_SCALE + RT / 2) / RT;
  localparam longint KP_CENTER =
    -((2000 * CART_NM_PER_REV * GAIN_SCALE + D_CART / 2) / D_CART);

  localparam longint SWING_TARGET =
    (100000000 * COUNTS_PER_REV + CART_NM_PER_REV / 2) / CART_NM_PER_REV;

  // thresholds turned into integer count limits
  localparam longint X_STOP_MAX = (30000000 * COUNTS_PER_REV - 1) / CART_NM_PER_REV;
  localparam longint ETH_STOP_MIN = (3041593 * COUNTS_PER_REV) / TWO_PI_E6 + 1;
  localparam longint DTH_STOP_MAX = (RT / 250 - 1) / (TWO_PI_E6 * 20);
  localparam longint ETH_BAL_MAX = (200000 * COUNTS_PER_REV - 1) / TWO_PI_E6;
  localparam longint DTH_BAL_MIN = (RT / 100) / (TWO_PI_E6 * 20) + 1;
  localparam longint DTH_BAL_MAX = (3 * RT / 50 - 1) / (TWO_PI_E6 * 20);
  localparam longint X_GUARD_MIN = (200000000 * COUNTS_PER_REV) / CART_NM_PER_REV + 1;
  localparam longint TIME_OK_TICKS = (500000000 + TICK_NS - 1) / TICK_NS;

  // floor(2^32 / 25) for the divide by 200
  localparam longint DIV_RECIP = (64'd1 << 32) / 25;

  localparam logic [2:0] M_LEFT = 3'd0;
  localparam logic [2:0] M_RIGHT = 3'd1;
  localparam logic [2:0] M_BAL = 3'd2;
  localparam logic [2:0] M_CENTER = 3'd3;
  localparam logic [2:0] M_STOP = 3'd4;

  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_GUARD = 3'd1;
  localparam logic [2:0] ST_CENTRED = 3'd2;
  localparam logic [2:0] ST_TRIG = 3'd3;
  localparam logic [2:0] ST_IDLE = 3'd4;

  localparam logic [0:0] REG_CART_END = 1'd0;
  localparam logic [0:0] REG_ANGLE_REF = 1'd1;

  localparam logic [2:0] SEL_CART_P = 3'd0;
  localparam logic [2:0] SEL_CART_D = 3'd1;
  localparam logic [2:0] SEL_PEND_P = 3'd2;
  localparam logic [2:0] SEL_PEND_D = 3'd3;
  localparam logic [2:0] SEL_DIV = 3'd4;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       acc_clr;
    logic       acc_add;
    logic       rnd;
    logic       num;
    logic       qc;
    logic       fin;
  } cmd_t;

  typedef struct packed {
    logic early;
  } stat_t;

endpackage

FILE: hdl/psbc_if.sv
// item channels of the controller: tick in, result out
interface psbc_tick_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cart_count;
  logic signed [31:0] pendulum_count;
  logic               trigger_level;
  logic               start_run;

  modport source (output valid, cart_count, pendulum_count, trigger_level, start_run,
                  input ready);
  modport sink (input valid, cart_count, pendulum_count, trigger_level, start_run,
                output ready);
endinterface

interface psbc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic [2:0]         run_status;
  logic [2:0]         mode;

  modport source (output valid, drive, run_status, mode, input ready);
  modport sink (input valid, drive, run_status, mode, output ready);
endinterface

FILE: hdl/psbc_dp.sv
// datapath: offsets, mode decisions, shared multiplier, filter and result register
module psbc_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] cart_count,
  input  logic signed [31:0] pendulum_count,
  input  logic               trigger_level,
  input  logic               start_run,
  input  psbc_pkg::cmd_t     cmd,
  output psbc_pkg::stat_t    stat,
  output logic signed [15:0] drive,
  output logic [2:0]         run_status,
  output logic [2:0]         mode
);

  localparam int RB = psbc_pkg::REV_BITS;

  logic signed [31:0] cart_end, angle_ref;
  logic signed [31:0] cin, pin;
  logic               trig, start;

  logic [2:0]         mode_q;
  logic [8:0]         elapsed;
  logic signed [31:0] prev_x, prev_th;
  logic signed [23:0] prev_u, prev_f;

  logic signed [31:0] x_r, th_r;
  logic signed [33:0] ex_r;
  logic signed [21:0] cdx_r, cdth_r;
  logic signed [RB:0] eth_r;
  logic signed [23:0] kpc_r, kdc_r, kpp_r, kdp_r;
  logic [2:0]         status_r;

  logic signed [62:0] prod;
  logic signed [47:0] acc;
  logic signed [23:0] u_r, f_r;
  logic [27:0]        div_a;
  logic               nneg;

  // tick evaluation
  logic [2:0]         mode_eff, mode_new, status_c;
  logic [8:0]         el_eff, el_new;
  logic signed [31:0] px, pth, x, th;
  logic signed [32:0] xe, ax, dx, dth;
  logic signed [33:0] ndx, ndth, adth, ex;
  logic signed [21:0] cdx, cdth;
  logic [RB-1:0]      e_lo;
  logic signed [RB:0] eth, aeth;
  logic signed [23:0] kpc, kdc, kpp, kdp;
  logic signed [15:0] target;
  logic               idle, timeok;

  always_comb begin
    mode_eff = start ? psbc_pkg::M_LEFT : mode_q;
    el_eff = start ? 9'd0 : elapsed;
    px = start ? 32'sd0 : prev_x;
    pth = start ? 32'(psbc_pkg::HALF_REV) : prev_th;
    idle = (mode_eff == psbc_pkg::M_STOP);
    x = cin - cart_end - 32'(psbc_pkg::CENTER_OFFSET);
    th = pin - angle_ref + 32'(psbc_pkg::HALF_REV);
    xe = 33'(x);
    ax = xe[32] ? -xe : xe;
    dx = 33'(x) - 33'(px);
    dth = 33'(th) - 33'(pth);
    ndx = -34'(dx);
    ndth = -34'(dth);
    adth = dth[32] ? ndth : 34'(dth);
    if (ndx > 34'(psbc_pkg::VEL_CLAMP)) cdx = 22'(psbc_pkg::VEL_CLAMP);
    else if (ndx < -34'(psbc_pkg::VEL_CLAMP)) cdx = -22'(psbc_pkg::VEL_CLAMP);
    else cdx = 22'(ndx);
    if (ndth > 34'(psbc_pkg::VEL_CLAMP)) cdth = 22'(psbc_pkg::VEL_CLAMP);
    else if (ndth < -34'(psbc_pkg::VEL_CLAMP)) cdth = -22'(psbc_pkg::VEL_CLAMP);
    else cdth = 22'(ndth);
    // error of the negated angle wrapped to half a revolution, +half kept for th >= 0
    e_lo = -th[RB-1:0];
    if (!th[31] && e_lo == {1'b1, {(RB-1){1'b0}}}) eth = (RB+1)'(psbc_pkg::HALF_REV);
    else eth = signed'({e_lo[RB-1], e_lo});
    aeth = eth[RB] ? -eth : eth;
    timeok = (10'(el_eff) >= 10'(psbc_pkg::TIME_OK_TICKS));
    el_new = (el_eff != 9'd511) ? el_eff + 9'd1 : el_eff;

    kpc = 24'sd0;
    kdc = 24'sd0;
    kpp = 24'sd0;
    kdp = 24'sd0;
    target = 16'sd0;
    mode_new = mode_eff;
    unique case (mode_eff)
      psbc_pkg::M_LEFT: begin
        kpc = 24'(psbc_pkg::KP_SWING);
        target = -16'(psbc_pkg::SWING_TARGET);
        if (timeok && th < pth) mode_new = psbc_pkg::M_RIGHT;
      end
      psbc_pkg::M_RIGHT: begin
        kpc = 24'(psbc_pkg::KP_SWING);
        target = 16'(psbc_pkg::SWING_TARGET);
        if (timeok && th > pth) mode_new = psbc_pkg::M_LEFT;
      end
      psbc_pkg::M_BAL: begin
        kpc = 24'(psbc_pkg::KP_BAL);
        kdc = 24'(psbc_pkg::KD_BAL);
        kpp = 24'(psbc_pkg::KPP_BAL);
        kdp = 24'(psbc_pkg::KDP_BAL);
      end
      default: begin
        kpc = 24'(psbc_pkg::KP_CENTER);
      end
    endcase
    ex = 34'(target) - 34'(x);

    status_c = psbc_pkg::ST_RUN;
    priority if (idle) begin
      status_c = psbc_pkg::ST_IDLE;
    end else if (mode_eff == psbc_pkg::M_CENTER && ax <= 33'(psbc_pkg::X_STOP_MAX) &&
                 aeth >= (RB+1)'(psbc_pkg::ETH_STOP_MIN) &&
                 adth <= 34'(psbc_pkg::DTH_STOP_MAX)) begin
      mode_new = psbc_pkg::M_STOP;
      status_c = psbc_pkg::ST_CENTRED;
    end else begin
      if (mode_new != psbc_pkg::M_BAL && mode_new != psbc_pkg::M_CENTER &&
          aeth <= (RB+1)'(psbc_pkg::ETH_BAL_MAX) &&
          adth >= 34'(psbc_pkg::DTH_BAL_MIN) && adth <= 34'(psbc_pkg::DTH_BAL_MAX))
        mode_new = psbc_pkg::M_BAL;
      priority if (mode_new != psbc_pkg::M_CENTER && timeok &&
                   ax >= 33'(psbc_pkg::X_GUARD_MIN)) begin
        mode_new = psbc_pkg::M_CENTER;
        status_c = psbc_pkg::ST_GUARD;
      end else if (!trig) begin
        mode_new = psbc_pkg::M_STOP;
        status_c = psbc_pkg::ST_TRIG;
      end else begin
        status_c = psbc_pkg::ST_RUN;
      end
    end
    stat.early = (status_c != psbc_pkg::ST_RUN);
  end

  // multiplier operands
  logic signed [33:0] a_op;
  logic signed [28:0] b_op;

  always_comb begin
    unique case (cmd.mul_sel)
      psbc_pkg::SEL_CART_P: begin
        a_op = ex_r;
        b_op = 29'(kpc_r);
      end
      psbc_pkg::SEL_CART_D: begin
        a_op = 34'(cdx_r);
        b_op = 29'(kdc_r);
      end
      psbc_pkg::SEL_PEND_P: begin
        a_op = 34'(eth_r);
        b_op = 29'(kpp_r);
      end
      psbc_pkg::SEL_PEND_D: begin
        a_op = 34'(cdth_r);
        b_op = 29'(kdp_r);
      end
      default: begin
        a_op = signed'({6'd0, div_a});
        b_op = 29'(psbc_pkg::DIV_RECIP);
      end
    endcase
  end

  // raw drive: round acc / 256 half away from zero, saturate to 24 bits
  logic signed [47:0] aacc, r1, rv;
  logic signed [23:0] u_c;
  always_comb begin
    aacc = acc[47] ? -acc : acc;
    r1 = (aacc + 48'sd128) >>> 8;
    rv = acc[47] ? -r1 : r1;
    if (rv > 48'sd8388607) u_c = 24'sd8388607;
    else if (rv < -48'sd8388608) u_c = -24'sd8388608;
    else u_c = 24'(rv);
  end

  // filter numerator 190*prev_f + 5*(u + prev_u)
  logic signed [33:0] pf34, s34, n34, an34, m34;
  always_comb begin
    pf34 = 34'(prev_f);
    s34 = 34'(u_r) + 34'(prev_u);
    n34 = (pf34 <<< 7) + (pf34 <<< 6) - (pf34 <<< 1) + (s34 <<< 2) + s34;
    an34 = n34[33] ? -n34 : n34;
    m34 = an34 + 34'sd100;
  end

  // quotient correction for the divide by 200
  logic [23:0]        q0;
  logic [29:0]        rem;
  logic [24:0]        q;
  logic signed [25:0] fv;
  logic signed [23:0] f_c;
  always_comb begin
    q0 = prod[55:32];
    rem = 30'(div_a) - ((30'(q0) << 4) + (30'(q0) << 3) + 30'(q0));
    q = (rem >= 30'd25) ? 25'(q0) + 25'd1 : 25'(q0);
    fv = nneg ? -signed'(26'(q)) : signed'(26'(q));
    if (fv > 26'sd8388607) f_c = 24'sd8388607;
    else if (fv < -26'sd8388608) f_c = -24'sd8388608;
    else f_c = 24'(fv);
  end

  logic commit;
  assign commit = cmd.fin && (status_r == psbc_pkg::ST_RUN);

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_end <= 32'sd0;
      angle_ref <= 32'sd0;
      mode_q <= psbc_pkg::M_STOP;
      elapsed <= 9'd0;
      prev_x <= 32'sd0;
      prev_th <= 32'(psbc_pkg::HALF_REV);
      prev_u <= 24'sd0;
      prev_f <= 24'sd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          psbc_pkg::REG_CART_END: cart_end <= signed'(cfg_data);
          default: angle_ref <= signed'(cfg_data);
        endcase
      end
      if (cmd.prep) begin
        if (start) begin
          prev_x <= 32'sd0;
          prev_th <= 32'(psbc_pkg::HALF_REV);
          prev_u <= 24'sd0;
          prev_f <= 24'sd0;
        end
        if (!idle) begin
          mode_q <= mode_new;
          elapsed <= el_new;
        end
      end
      if (commit) begin
        prev_x <= x_r;
        prev_th <= th_r;
        prev_u <= u_r;
        prev_f <= f_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cin <= cart_count;
      pin <= pendulum_count;
      trig <= trigger_level;
      start <= start_run;
    end
    if (cmd.prep) begin
      x_r <= x;
      th_r <= th;
      ex_r <= ex;
      cdx_r <= cdx;
      cdth_r <= cdth;
      eth_r <= eth;
      kpc_r <= kpc;
      kdc_r <= kdc;
      kpp_r <= kpp;
      kdp_r <= kdp;
      status_r <= status_c;
    end
    if (cmd.mul_en) prod <= a_op * b_op;
    if (cmd.acc_clr) acc <= 48'sd0;
    else if (cmd.acc_add) acc <= acc + prod[47:0];
    if (cmd.rnd) u_r <= u_c;
    if (cmd.num) begin
      div_a <= 28'(m34 >>> 3);
      nneg <= n34[33];
    end
    if (cmd.qc) f_r <= f_c;
    if (cmd.fin) begin
      if (status_r != psbc_pkg::ST_RUN) drive <= 16'sd0;
      else if (f_r > 24'sd32767) drive <= 16'sd32767;
      else if (f_r < -24'sd32768) drive <= -16'sd32768;
      else drive <= 16'(f_r);
      run_status <= status_r;
      mode <= mode_q;
    end
  end

endmodule

FILE: hdl/psbc_ctrl.sv
// sequencer: handshakes and step order of one tick through the datapath
module psbc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  psbc_pkg::stat_t stat,
  output psbc_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_MUL0 = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_MUL3 = 4'd5;
  localparam logic [3:0] S_ACC = 4'd6;
  localparam logic [3:0] S_RND = 4'd7;
  localparam logic [3:0] S_NUM = 4'd8;
  localparam logic [3:0] S_DIVM = 4'd9;
  localparam logic [3:0] S_QC = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state, state_next;
  logic       slot_free;

  assign in_ready = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = psbc_pkg::SEL_CART_P;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_next = stat.early ? S_DONE : S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.acc_clr = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = psbc_pkg::SEL_CART_D;
        cmd.acc_add = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = psbc_pkg::SEL_PEND_P;
        cmd.acc_add = 1'b1;
        state_next = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = psbc_pkg::SEL_PEND_D;
        cmd.acc_add = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        state_next = S_NUM;
      end
      S_NUM: begin
        cmd.num = 1'b1;
        state_next = S_DIVM;
      end
      S_DIVM: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = psbc_pkg::SEL_DIV;
        state_next = S_QC;
      end
      S_QC: begin
        cmd.qc = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        cmd.fin = slot_free;
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: hdl/pendulum_swingup_balance_controller.sv
// top level of the cart-pendulum swing-up and balance controller
//
// tick channel: one item per control tick with both encoder counts, the
// trigger level and start_run. result channel: one item per tick with the
// Q2.14 drive, run status and the mode after the tick. both channels move
// an item when valid and ready are high at a rising clock edge.
// cfg_we/cfg_index/cfg_data write the cart end count (index 0) and the
// pendulum rest count (index 1); write them only while no tick is in work.
// after acceptance a tick is prepared; then the four gain products and the
// divide-by-200 reciprocal go one after another through a single registered
// multiplier on the way to the result register. idle, stopping and guard
// ticks skip the multiplier and go from the prep step to the finish. a new
// tick is taken once the previous one has reached the result register;
// only a tick's own finish waits for the result register to free. a
// stalled receiver holds the result stable.
// synchronous reset clears both registers, stops the run (mode stopped)
// and empties the result register.
module pendulum_swingup_balance_controller (
  input  logic                 clk,
  input  logic                 rst,
  psbc_tick_if.sink            tick,
  psbc_result_if.source        result,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  psbc_pkg::cmd_t  cmd;
  psbc_pkg::stat_t stat;
  logic            in_ready, out_valid;

  psbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tick.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psbc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cart_count     (tick.cart_count),
    .pendulum_count (tick.pendulum_count),
    .trigger_level  (tick.trigger_level),
    .start_run      (tick.start_run),
    .cmd            (cmd),
    .stat           (stat),
    .drive          (result.drive),
    .run_status     (result.run_status),
    .mode           (result.mode)
  );

  assign tick.ready = in_ready;
  assign result.valid = out_valid;

  // only a running tick may drive the motor
  a_drive_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.run_status != psbc_pkg::ST_RUN) |-> result.drive == 16'sd0)
    else $error("nonzero drive on a non-running result");

  // a stopped mode comes only with a stop or idle status
  a_stop_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.mode == psbc_pkg::M_STOP) |->
      (result.run_status == psbc_pkg::ST_CENTRED || result.run_status == psbc_pkg::ST_TRIG ||
       result.run_status == psbc_pkg::ST_IDLE))
    else $error("stopped mode with running status");

  // the edge guard always leaves the run centering
  a_guard_mode: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.run_status == psbc_pkg::ST_GUARD) |->
      result.mode == psbc_pkg::M_CENTER)
    else $error("edge guard without centering mode");

endmodule

FILE: verif/pendulum_swingup_balance_controller_test.sv
// self-checking testbench of the swing-up and balance controller: tick stimulus, result checks
`timescale 1ns / 1ps

module pendulum_swingup_balance_controller_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic signed [15:0] drive;
    logic [2:0]         run_status;
    logic [2:0]         mode;
  } control_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = psbc_pkg::REG_CART_END;
  logic [31:0] cfg_data = '0;

  psbc_tick_if tick_ch ();
  psbc_result_if res_ch ();

  pendulum_swingup_balance_controller dut (
    .clk(clk), .rst(rst), .tick(tick_ch), .result(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // controller model state
  longint cart_end_q, angle_ref_q;
  logic [2:0] mode_q;
  int ticks_q;
  longint prev_x, prev_th, prev_u, prev_f;
  longint kp_swing, kp_bal, kd_bal, kpp_bal, kdp_bal, kp_center, swing_target;

  control_out_t expected_q[$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic longint rdiv(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint wrap32(longint v);
    logic [63:0] t;
    logic signed [31:0] s;
    t = v;
    s = t[31:0];
    return longint'(s);
  endfunction

  function automatic longint wrap_half(longint e);
    if (e > 0) return ((e + 2048) % 4096) - 2048;
    return 2048 - ((2048 - e) % 4096);
  endfunction

  task automatic restart_run(logic [2:0] m);
    mode_q = m;
    ticks_q = 0;
    prev_x = 0;
    prev_th = 2048;
    prev_u = 0;
    prev_f = 0;
  endtask

  function automatic control_out_t pack_out(longint drv, logic [2:0] st);
    control_out_t r;
    r.drive = drv[15:0];
    r.run_status = st;
    r.mode = mode_q;
    return r;
  endfunction

  task automatic predict_tick(input logic signed [31:0] cc, pc, input logic trig, st,
                              output control_out_t r);
    longint rt, x, th, dx, dth, target, ex, eth, vel, acc, u, f, kpc, kdc, kpp, kdp;
    logic [2:0] gm;
    bit timeok;
    rt = 64'd4096 * 64'd2000000;
    target = 0; kpc = 0; kdc = 0; kpp = 0; kdp = 0;
    if (st) restart_run(psbc_pkg::M_LEFT);
    if (mode_q == psbc_pkg::M_STOP) begin
      r = pack_out(0, psbc_pkg::ST_IDLE);
      return;
    end
    x = wrap32(longint'(cc) - cart_end_q - 6145);
    th = wrap32(longint'(pc) - angle_ref_q + 2048);
    dx = x - prev_x;
    dth = th - prev_th;
    timeok = longint'(ticks_q) * 2000000 >= 500000000;
    if (ticks_q < 511) ticks_q++;
    gm = mode_q;
    if (gm == psbc_pkg::M_LEFT || gm == psbc_pkg::M_RIGHT) begin
      kpc = kp_swing;
      target = gm == psbc_pkg::M_LEFT ? -swing_target : swing_target;
      if (timeok && gm == psbc_pkg::M_LEFT && th < prev_th) mode_q = psbc_pkg::M_RIGHT;
      if (timeok && gm == psbc_pkg::M_RIGHT && th > prev_th) mode_q = psbc_pkg::M_LEFT;
    end else if (gm == psbc_pkg::M_BAL) begin
      kpc = kp_bal; kdc = kd_bal; kpp = kpp_bal; kdp = kdp_bal;
    end else begin
      kpc = kp_center;
    end
    ex = target - x;
    eth = wrap_half(-th);
    vel = mag(dth) * 6283185 * 20;
    if (gm == psbc_pkg::M_CENTER && mag(x) * 149964849 < 64'd30000000 * 4096 &&
        mag(eth) * 6283185 > 64'd3041593 * 4096 && vel < rt / 250) begin
      mode_q = psbc_pkg::M_STOP;
      r = pack_out(0, psbc_pkg::ST_CENTRED);
      return;
    end
    if (mode_q != psbc_pkg::M_BAL && mode_q != psbc_pkg::M_CENTER &&
        mag(eth) * 6283185 < 64'd200000 * 4096 &&
        vel > rt / 100 && vel < 3 * rt / 50)
      mode_q = psbc_pkg::M_BAL;
    if (mode_q != psbc_pkg::M_CENTER && timeok &&
        mag(x) * 149964849 > 64'd200000000 * 4096) begin
      mode_q = psbc_pkg::M_CENTER;
      r = pack_out(0, psbc_pkg::ST_GUARD);
      return;
    end
    if (!trig) begin
      mode_q = psbc_pkg::M_STOP;
      r = pack_out(0, psbc_pkg::ST_TRIG);
      return;
    end
    acc = kpc * ex + kdc * clamp(-dx, -1048576, 1048576) + kpp * eth +
          kdp * clamp(-dth, -1048576, 1048576);
    u = clamp(rdiv(acc, 256), -8388608, 8388607);
    f = clamp(rdiv(190 * prev_f + 5 * (u + prev_u), 200), -8388608, 8388607);
    prev_f = f;
    prev_u = u;
    prev_x = x;
    prev_th = th;
    r = pack_out(clamp(f, -32768, 32767), psbc_pkg::ST_RUN);
  endtask

  // one tick item; caller is at a rising edge
  task automatic send_tick(logic signed [31:0] cc, pc, logic trig, st);
    control_out_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
      if (gap > 0) begin
        tick_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tick_ch.valid <= 1'b1;
    tick_ch.cart_count <= cc;
    tick_ch.pendulum_count <= pc;
    tick_ch.trigger_level <= trig;
    tick_ch.start_run <= st;
    do @(posedge clk); while (!tick_ch.ready);
    predict_tick(cc, pc, trig, st, r);
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic wait_drained();
    tick_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] cart_end, logic [31:0] angle_ref);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= psbc_pkg::REG_CART_END;
    cfg_data <= cart_end;
    @(posedge clk);
    cfg_index <= psbc_pkg::REG_ANGLE_REF;
    cfg_data <= angle_ref;
    @(posedge clk);
    cfg_we <= 1'b0;
    cart_end_q = longint'(signed'(cart_end));
    angle_ref_q = longint'(signed'(angle_ref));
  endtask

  // counts relative to centre and hanging-down position
  task automatic send_rel(longint c, longint p, logic trig, st);
    send_tick(32'(wrap32(cart_end_q + 6145 + c)), 32'(wrap32(angle_ref_q + p)), trig, st);
  endtask

  task automatic test_directed();
    send_rel(0, 0, 1'b1, 1'b0);                       // idle after reset
    send_tick(32'sh7fffffff, 32'sh80000000, 1'b1, 1'b0);
    send_rel(0, 0, 1'b1, 1'b1);
    send_tick(32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b0);   // huge velocities clamp
    send_tick(32'sh80000000, 32'sh80000000, 1'b1, 1'b0);
    send_tick(32'sh80000000, 32'sh7fffffff, 1'b1, 1'b0);
    send_rel(0, 0, 1'b0, 1'b0);                       // trigger loss
    send_rel(0, 0, 1'b1, 1'b0);                       // idle again
    send_rel(100, -2048, 1'b1, 1'b1);
    send_rel(100, -2046, 1'b1, 1'b0);                 // upright and moving: balance
    send_rel(90, -2044, 1'b1, 1'b0);
    send_rel(80, -2045, 1'b1, 1'b0);
    send_rel(-4000, 2047, 1'b1, 1'b0);
    send_rel(4000, -1, 1'b1, 1'b0);
    send_rel(0, 0, 1'b0, 1'b1);                       // start with trigger low
    send_tick(0, 0, 1'b1, 1'b1);
    send_tick(32'sh7fffffff, 0, 1'b1, 1'b0);
  endtask

  // swing-up style run: pendulum oscillates (or jitters near upright) and cart wanders
  task automatic swing_run(int n, bit upright);
    longint c, p, dp;
    c = longint'($urandom_range(0, 200)) - 100;
    p = upright ? -2048 : 0;
    dp = 2;
    for (int i = 0; i < n; i++) begin
      if (upright) begin
        p += $urandom_range(0, 1) ? dp : -dp;
        dp = $urandom_range(0, 3);
        if (p > -2020 || p < -2076) p = -2048;
      end else begin
        p += dp;
        if (p > 1500 || p < -1500) dp = -dp;
        if ($urandom_range(0, 7) == 0) dp = longint'($urandom_range(0, 80)) - 40;
      end
      c += longint'($urandom_range(0, 60)) - 30;
      send_rel(c, p, $urandom_range(0, 99) != 0, i == 0);
    end
  endtask

  // long run: cart drifts past the edge, gets centred with pendulum hanging still
  task automatic edge_run(int n);
    longint c, p;
    c = 0;
    p = 0;
    for (int i = 0; i < n; i++) begin
      if (i < 270) c = c < 7000 ? c + 30 : c;
      else c = c > 60 ? c - 60 : 0;
      if (i > 380 && $urandom_range(0, 3) == 0) p = longint'($urandom_range(0, 3)) - 1;
      send_rel($urandom_range(0, 1) ? c : -c, p, i < n - 3 || $urandom_range(0, 1), i == 0);
      if (i == 0 && $urandom_range(0, 1)) c = -c;
    end
  endtask

  task automatic test_noise(int n);
    for (int i = 0; i < n; i++)
      send_tick($urandom, $urandom, $urandom_range(0, 7) != 0, $urandom_range(0, 15) == 0);
  endtask

  task automatic test_runs();
    for (int k = 0; k < 6; k++) swing_run($urandom_range(20, 60), k[0]);
    swing_run(300, 1'b0);
    edge_run(420);
  endtask

  // result checker with its own stall pattern
  int stall_left = 0;
  int pattern_kind = 0;
  int pattern_cycles = 0;
  always @(posedge clk) begin
    control_out_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result drive %0d status %0d mode %0d", $time,
                 res_ch.drive, res_ch.run_status, res_ch.mode);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_ch.drive !== e.drive) begin
          $display("%0t: drive expected %0d actual %0d", $time, e.drive, res_ch.drive);
          errors++;
        end
        if (res_ch.run_status !== e.run_status) begin
          $display("%0t: run_status expected %0d actual %0d", $time, e.run_status,
                   res_ch.run_status);
          errors++;
        end
        if (res_ch.mode !== e.mode) begin
          $display("%0t: mode expected %0d actual %0d", $time, e.mode, res_ch.mode);
          errors++;
        end
      end
    end
    if (pattern_cycles == 0) begin
      pattern_kind = $urandom_range(0, 2);
      pattern_cycles = $urandom_range(20, 120);
    end
    pattern_cycles--;
    if (stall_left > 0) stall_left--;
    else if (pattern_kind == 1 && $urandom_range(0, 1)) stall_left = 1;
    else if (pattern_kind == 2 && $urandom_range(0, 5) == 0) stall_left = $urandom_range(2, 9);
    res_ch.ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.cart_count = '0;
    tick_ch.pendulum_count = '0;
    tick_ch.trigger_level = 1'b0;
    tick_ch.start_run = 1'b0;
    res_ch.ready = 1'b0;
    kp_swing = rdiv(-3800 * 64'd149964849 * 4194304, 64'd1000000000000 * 4096);
    kp_bal = rdiv(3800 * 64'd149964849 * 4194304, 64'd1000000000000 * 4096);
    kd_bal = rdiv(2400 * 64'd149964849 * 4194304, 64'd1000 * 4096 * 2000000);
    kpp_bal = rdiv(5700 * 64'd6283185 * 4194304, 64'd1000000000 * 4096);
    kdp_bal = rdiv(800 * 64'd6283185 * 4194304, 64'd4096 * 2000000);
    kp_center = rdiv(-2000 * 64'd149964849 * 4194304, 64'd1000000000000 * 4096);
    swing_target = rdiv(64'd100000000 * 4096, 64'd149964849);
    cart_end_q = 0;
    angle_ref_q = 0;
    restart_run(psbc_pkg::M_STOP);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_regs(32'h7fffffff, 32'h80000000);
    test_directed();
    write_regs($urandom, $urandom);
    test_runs();
    write_regs(32'h80000000, 32'h7fffffff);
    test_noise(120);
    swing_run(40, 1'b1);
    write_regs($urandom_range(0, 20000) - 10000, $urandom_range(0, 20000) - 10000);
    swing_run(120, 1'b0);
    test_noise(120);
    wait_drained();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: pendulum_swingup_balance_controller.f
hdl/psbc_pkg.sv
hdl/psbc_if.sv
hdl/psbc_dp.sv
hdl/psbc_ctrl.sv
hdl/pendulum_swingup_balance_controller.sv
verif/pendulum_swingup_balance_controller_test.sv
